@@ sv/lva_pkg.sv @@
// ----------------------------------------------------------------------------
// lva_pkg
// Shared types, codes and constants of the LRU voice allocator.
// ----------------------------------------------------------------------------
package lva_pkg;

    localparam int NUM_VOICES_DEF = 8;
    localparam int NUM_NOTES      = 128;
    localparam int NOTE_W         = 7;
    localparam int VEL_W          = 7;
    localparam int MASK_W         = 8;
    localparam int VOICE_W        = 3;
    localparam int VIDX_MAX_W     = 5;

    typedef enum logic [1:0] {
        FUNC_NOTE_ON  = 2'd0,
        FUNC_NOTE_OFF = 2'd1,
        FUNC_ALL_OFF  = 2'd2,
        FUNC_UNUSED   = 2'd3
    } lva_func_t;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_RELEASE = 1'b1
    } lva_cmd_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic [MASK_W-1:0] active_mask;
    } lva_in_req_t;

    typedef struct packed {
        logic               command;
        logic [VOICE_W-1:0] voice;
        logic [NOTE_W-1:0]  out_note;
        logic [VEL_W-1:0]   out_velocity;
        logic               stolen;
        logic               last;
    } lva_out_req_t;

    typedef struct packed {
        logic rotate;
        logic compact;
    } lva_cell_ctrl_t;

endpackage

@@ sv/lru_voice_allocator.sv @@
// Note on: ST_SCAN rotates the whole use order through the cell chain, then ST_UPDATE
// puts the start request into the output register once that register is free.
// Note off: the table is read in the accept cycle; ST_NOTE_OFF moves the read result to the output register.
// All notes off: ST_ANO_SCAN steps over the voices, and ST_ANO_OUT releases each active one.
// One request is worked on at a time; the output register frees the input side.
// Reset is asynchronous and restores the FSM, use order and table valid bits at once, with no sweep.
// ----------------------------------------------------------------------------
// lru_voice_allocator
// Polyphonic voice allocator with oldest-first voice stealing.
// ----------------------------------------------------------------------------
module lru_voice_allocator #(
    parameter int NUM_VOICES = lva_pkg::NUM_VOICES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lva_pkg::lva_in_req_t in_req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lva_pkg::lva_out_req_t out_req
);

    localparam int VW      = $clog2(NUM_VOICES);
    localparam int ANO_LIM = (NUM_VOICES < 8) ? NUM_VOICES : 8;
    localparam logic [lva_pkg::MASK_W-1:0] LIM_MASK = lva_pkg::MASK_W'((1 << ANO_LIM) - 1);
    localparam logic [VW-1:0] LAST_V   = VW'(NUM_VOICES - 1);
    localparam logic [VW-1:0] ANO_LAST = VW'(ANO_LIM - 1);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_UPDATE   = 6'b000100,
        ST_NOTE_OFF = 6'b001000,
        ST_ANO_SCAN = 6'b010000,
        ST_ANO_OUT  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [VW-1:0]                   k_reg, k_next;
    logic [VW-1:0]                   pos_reg, pos_next;
    logic [VW-1:0]                   chosen_reg, chosen_next;
    logic                            found_reg, found_next;
    logic [VW-1:0]                   ano_v_reg, ano_v_next;
    logic [lva_pkg::NOTE_W-1:0]      note_reg, note_next;
    logic [lva_pkg::VEL_W-1:0]       vel_reg, vel_next;
    logic [lva_pkg::MASK_W-1:0]      mask_reg, mask_next;
    logic                            out_valid_reg, out_valid_next;
    lva_pkg::lva_out_req_t           out_req_reg, out_req_next;
    logic [lva_pkg::NOTE_W-1:0]      vn_reg [NUM_VOICES];

    logic [VW-1:0]                   order [NUM_VOICES];
    lva_pkg::lva_cell_ctrl_t         cell_ctrl;
    logic [VW-1:0]                   chosen_eff;
    logic [VW-1:0]                   pos_eff;
    logic [lva_pkg::VIDX_MAX_W-1:0]  head_ext;
    logic [lva_pkg::VIDX_MAX_W-1:0]  chosen_ext;
    logic [lva_pkg::VIDX_MAX_W-1:0]  av_ext;
    logic [lva_pkg::VIDX_MAX_W-1:0]  rd_ext;
    logic                            head_active;
    logic                            out_free;
    logic                            accept;
    logic                            vn_wr;
    logic                            tbl_wr;
    logic                            tbl_rd;
    logic [lva_pkg::NOTE_W-1:0]      tbl_rd_addr;
    logic [VW-1:0]                   tbl_rd_data;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_VOICES; gi++)
        begin : g_cell
            lva_order_cell #(
                .VW      (VW),
                .INDEX   (gi),
                .IS_TAIL (gi == NUM_VOICES - 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .pos      (pos_eff),
                .chosen   (chosen_eff),
                .neighbor (order[(gi + 1) % NUM_VOICES]),
                .value    (order[gi])
            );
        end
    endgenerate

    lva_note_table #(
        .VW (VW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr),
        .wr_addr (note_reg),
        .wr_data (chosen_eff),
        .rd_en   (tbl_rd),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign head_ext    = lva_pkg::VIDX_MAX_W'(order[0]);
    assign head_active = (head_ext < lva_pkg::VIDX_MAX_W'(8)) && mask_reg[head_ext[2:0]];
    assign chosen_eff  = found_reg ? chosen_reg : order[0];
    assign pos_eff     = found_reg ? pos_reg : '0;
    assign chosen_ext  = lva_pkg::VIDX_MAX_W'(chosen_eff);
    assign av_ext      = lva_pkg::VIDX_MAX_W'(ano_v_reg);
    assign rd_ext      = lva_pkg::VIDX_MAX_W'(tbl_rd_data);
    assign tbl_rd_addr = (state_reg == ST_IDLE) ? in_req.note : vn_reg[ano_v_reg];

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        chosen_next    = chosen_reg;
        found_next     = found_reg;
        ano_v_next     = ano_v_reg;
        note_next      = note_reg;
        vel_next       = vel_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_req_next   = out_req_reg;
        cell_ctrl      = '0;
        vn_wr          = 1'b0;
        tbl_wr         = 1'b0;
        tbl_rd         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    note_next  = in_req.note;
                    vel_next   = in_req.velocity;
                    mask_next  = in_req.active_mask;
                    k_next     = '0;
                    found_next = 1'b0;
                    ano_v_next = '0;
                    case (in_req.func)
                        lva_pkg::FUNC_NOTE_ON:
                        begin
                            state_next = ST_SCAN;
                        end
                        lva_pkg::FUNC_NOTE_OFF:
                        begin
                            tbl_rd     = 1'b1;
                            state_next = ST_NOTE_OFF;
                        end
                        lva_pkg::FUNC_ALL_OFF:
                        begin
                            mask_next  = in_req.active_mask & LIM_MASK;
                            state_next = ST_ANO_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cell_ctrl.rotate = 1'b1;
                if (!found_reg && !head_active)
                begin
                    found_next  = 1'b1;
                    chosen_next = order[0];
                    pos_next    = k_reg;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == LAST_V)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cell_ctrl.compact         = 1'b1;
                    vn_wr                     = 1'b1;
                    tbl_wr                    = 1'b1;
                    out_valid_next            = 1'b1;
                    out_req_next.command      = lva_pkg::CMD_START;
                    out_req_next.voice        = chosen_ext[2:0];
                    out_req_next.out_note     = note_reg;
                    out_req_next.out_velocity = vel_reg;
                    out_req_next.stolen       = !found_reg;
                    out_req_next.last         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            ST_NOTE_OFF:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_req_next.command      = lva_pkg::CMD_RELEASE;
                    out_req_next.voice        = rd_ext[2:0];
                    out_req_next.out_note     = '0;
                    out_req_next.out_velocity = '0;
                    out_req_next.stolen       = 1'b0;
                    out_req_next.last         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            ST_ANO_SCAN:
            begin
                if (mask_reg[av_ext[2:0]])
                begin
                    tbl_rd     = 1'b1;
                    state_next = ST_ANO_OUT;
                end
                else if (ano_v_reg == ANO_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ano_v_next = ano_v_reg + 1'b1;
                end
            end
            ST_ANO_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_req_next.command      = lva_pkg::CMD_RELEASE;
                    out_req_next.voice        = rd_ext[2:0];
                    out_req_next.out_note     = '0;
                    out_req_next.out_velocity = '0;
                    out_req_next.stolen       = 1'b0;
                    out_req_next.last         = ((mask_reg >> av_ext) >> 1) == '0;
                    if (out_req_next.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ano_v_next = ano_v_reg + 1'b1;
                        state_next = ST_ANO_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            pos_reg       <= '0;
            chosen_reg    <= '0;
            found_reg     <= 1'b0;
            ano_v_reg     <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                vn_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            chosen_reg    <= chosen_next;
            found_reg     <= found_next;
            ano_v_reg     <= ano_v_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            if (vn_wr)
            begin
                vn_reg[chosen_eff] <= note_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg    <= note_next;
        vel_reg     <= vel_next;
        out_req_reg <= out_req_next;
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

endmodule

@@ sv/lva_order_cell.sv @@
// ----------------------------------------------------------------------------
// lva_order_cell
// One slot of the use order. Rotates toward the head during a scan and
// closes the gap behind the chosen slot during an update.
// ----------------------------------------------------------------------------
module lva_order_cell #(
    parameter int VW      = 3,
    parameter int INDEX   = 0,
    parameter bit IS_TAIL = 1'b0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lva_pkg::lva_cell_ctrl_t ctrl,
    input  logic [VW-1:0]           pos,
    input  logic [VW-1:0]           chosen,
    input  logic [VW-1:0]           neighbor,
    output logic [VW-1:0]           value
);

    localparam logic [VW-1:0] IDX = VW'(INDEX);

    logic [VW-1:0] value_reg;
    logic [VW-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.rotate)
        begin
            value_next = neighbor;
        end
        else if (ctrl.compact && (IDX >= pos))
        begin
            value_next = IS_TAIL ? chosen : neighbor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= IDX;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

@@ sv/lva_note_table.sv @@
// ----------------------------------------------------------------------------
// lva_note_table
// Note-to-voice memory with one write and one registered read port.
// Entries never written read as voice zero.
// ----------------------------------------------------------------------------
module lva_note_table #(
    parameter int VW = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [lva_pkg::NOTE_W-1:0] wr_addr,
    input  logic [VW-1:0]             wr_data,
    input  logic                      rd_en,
    input  logic [lva_pkg::NOTE_W-1:0] rd_addr,
    output logic [VW-1:0]             rd_data
);

    logic [VW-1:0]                  mem [lva_pkg::NUM_NOTES];
    logic [lva_pkg::NUM_NOTES-1:0]  valid_reg;
    logic [VW-1:0]                  rd_data_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ verif/lru_voice_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_voice_allocator_tb
// Drives note on, note off, all notes off and unused events into the voice
// allocator with random idle gaps and output stalls. A local model of the use
// order, the note table and the voice notes predicts every command request,
// and each request that comes out is compared field by field in order.
// ----------------------------------------------------------------------------
module lru_voice_allocator_tb;

    localparam int N_VOICES   = lva_pkg::NUM_VOICES_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int GAP_MAX    = 18;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    lva_pkg::lva_in_req_t  in_req = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    lva_pkg::lva_out_req_t out_req;

    lva_pkg::lva_out_req_t       expected_cmds[$];
    logic [lva_pkg::VOICE_W-1:0] lru_order [N_VOICES];
    logic [lva_pkg::VOICE_W-1:0] note_voice [lva_pkg::NUM_NOTES];
    logic [lva_pkg::NOTE_W-1:0]  voice_key [N_VOICES];
    logic [lva_pkg::NOTE_W-1:0]  held_notes[$];

    int error_count = 0;
    int gap_max = GAP_MAX;
    int stall_max = GAP_MAX;
    int hold_cycles = 0;
    int idle_count = 0;

    lru_voice_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_req   (out_req)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic reset_allocation();
        for (int i = 0; i < N_VOICES; i++)
        begin
            lru_order[i] = lva_pkg::VOICE_W'(i);
            voice_key[i] = '0;
        end
        for (int i = 0; i < lva_pkg::NUM_NOTES; i++)
        begin
            note_voice[i] = '0;
        end
    endtask

    task automatic predict_voice_commands(input lva_pkg::lva_in_req_t req);
        lva_pkg::lva_out_req_t cmd;
        int pos;
        int total;
        int seen;
        logic [lva_pkg::VOICE_W-1:0] v;
        cmd = '0;
        pos = -1;
        seen = 0;
        case (lva_pkg::lva_func_t'(req.func))
            lva_pkg::FUNC_NOTE_ON:
            begin
                for (int i = 0; i < N_VOICES; i++)
                begin
                    if (pos < 0 && !req.active_mask[lru_order[i]])
                    begin
                        pos = i;
                    end
                end
                cmd.stolen = (pos < 0);
                if (pos < 0)
                begin
                    pos = 0;
                end
                v = lru_order[pos];
                for (int i = pos; i < N_VOICES - 1; i++)
                begin
                    lru_order[i] = lru_order[i + 1];
                end
                lru_order[N_VOICES - 1] = v;
                note_voice[req.note] = v;
                voice_key[v] = req.note;
                cmd.command = lva_pkg::CMD_START;
                cmd.voice = v;
                cmd.out_note = req.note;
                cmd.out_velocity = req.velocity;
                cmd.last = 1'b1;
                expected_cmds.push_back(cmd);
            end
            lva_pkg::FUNC_NOTE_OFF:
            begin
                cmd.command = lva_pkg::CMD_RELEASE;
                cmd.voice = note_voice[req.note];
                cmd.last = 1'b1;
                expected_cmds.push_back(cmd);
            end
            lva_pkg::FUNC_ALL_OFF:
            begin
                total = $countones(req.active_mask);
                for (int i = 0; i < N_VOICES; i++)
                begin
                    if (req.active_mask[i])
                    begin
                        seen++;
                        cmd.command = lva_pkg::CMD_RELEASE;
                        cmd.voice = note_voice[voice_key[i]];
                        cmd.last = (seen == total);
                        expected_cmds.push_back(cmd);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_event(input lva_pkg::lva_func_t func, input int note,
                              input int vel, input int mask);
        int gap;
        lva_pkg::lva_in_req_t req;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        req.func = func;
        req.note = lva_pkg::NOTE_W'(note);
        req.velocity = lva_pkg::VEL_W'(vel);
        req.active_mask = lva_pkg::MASK_W'(mask);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        do
            @(posedge clk);
        while (!in_ready);
        predict_voice_commands(req);
        if (func == lva_pkg::FUNC_NOTE_ON)
        begin
            held_notes.push_back(req.note);
            if (held_notes.size() > 16)
            begin
                void'(held_notes.pop_front());
            end
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_cmds.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_command(input lva_pkg::lva_out_req_t got);
        lva_pkg::lva_out_req_t want;
        if (expected_cmds.size() == 0)
        begin
            report_mismatch("unexpected request, voice", got.voice, 0);
            return;
        end
        want = expected_cmds.pop_front();
        if (got.command !== want.command)
            report_mismatch("command", got.command, want.command);
        if (got.voice !== want.voice)
            report_mismatch("voice", got.voice, want.voice);
        if (got.out_note !== want.out_note)
            report_mismatch("out_note", got.out_note, want.out_note);
        if (got.out_velocity !== want.out_velocity)
            report_mismatch("out_velocity", got.out_velocity, want.out_velocity);
        if (got.stolen !== want.stolen)
            report_mismatch("stolen", got.stolen, want.stolen);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            check_command(out_req);
        end
    end

    initial
    begin
        while (idle_count < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic test_directed();
        send_event(lva_pkg::FUNC_NOTE_ON, 0, 127, 8'h00);
        send_event(lva_pkg::FUNC_NOTE_ON, 127, 0, 8'h01);
        send_event(lva_pkg::FUNC_NOTE_ON, 60, 64, 8'hFF);
        send_event(lva_pkg::FUNC_NOTE_ON, 61, 1, 8'hFE);
        send_event(lva_pkg::FUNC_NOTE_ON, 62, 100, 8'h7F);
        send_event(lva_pkg::FUNC_NOTE_OFF, 60, 0, 8'hFF);
        send_event(lva_pkg::FUNC_NOTE_OFF, 127, 127, 8'h00);
        send_event(lva_pkg::FUNC_NOTE_OFF, 5, 0, 8'h00);
        send_event(lva_pkg::FUNC_NOTE_OFF, 0, 0, 8'h55);
        send_event(lva_pkg::FUNC_ALL_OFF, 0, 0, 8'h00);
        send_event(lva_pkg::FUNC_ALL_OFF, 127, 127, 8'hFF);
        send_event(lva_pkg::FUNC_ALL_OFF, 3, 0, 8'h81);
        send_event(lva_pkg::FUNC_UNUSED, 127, 127, 8'hFF);
        send_event(lva_pkg::FUNC_NOTE_ON, 64, 127, 8'hFF);
        send_event(lva_pkg::FUNC_NOTE_ON, 64, 10, 8'h00);
        send_event(lva_pkg::FUNC_NOTE_OFF, 64, 0, 8'hAA);
        send_event(lva_pkg::FUNC_ALL_OFF, 0, 0, 8'hAA);
        send_event(lva_pkg::FUNC_UNUSED, 0, 0, 8'h00);
        send_event(lva_pkg::FUNC_NOTE_ON, 100, 90, 8'h55);
        send_event(lva_pkg::FUNC_NOTE_ON, 101, 91, 8'hAA);
        send_event(lva_pkg::FUNC_ALL_OFF, 0, 0, 8'h5A);
    endtask

    task automatic send_random_event();
        int pick;
        int mask;
        int note;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: mask = 8'h00;
            1: mask = 8'hFF;
            default: mask = $urandom_range(0, 255);
        endcase
        note = $urandom_range(0, lva_pkg::NUM_NOTES - 1);
        if (pick < 50)
            send_event(lva_pkg::FUNC_NOTE_ON, note, $urandom_range(0, 127), mask);
        else if (pick < 80)
        begin
            if (held_notes.size() != 0 && $urandom_range(0, 9) < 7)
                note = held_notes[$urandom_range(0, held_notes.size() - 1)];
            send_event(lva_pkg::FUNC_NOTE_OFF, note, $urandom_range(0, 127), mask);
        end
        else if (pick < 92)
            send_event(lva_pkg::FUNC_ALL_OFF, note, $urandom_range(0, 127), mask);
        else
            send_event(lva_pkg::lva_func_t'($urandom_range(0, 3)), note,
                       $urandom_range(0, 127), mask);
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 200; i++)
        begin
            if (i % 25 == 0)
            begin
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            end
            send_random_event();
        end
        gap_max = GAP_MAX;
        stall_max = GAP_MAX;
    endtask

    task automatic test_no_idle();
        gap_max = 0;
        stall_max = 0;
        for (int i = 0; i < 40; i++)
        begin
            send_random_event();
        end
        gap_max = GAP_MAX;
        stall_max = GAP_MAX;
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        gap_max = 0;
        hold_cycles = 300;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 3 == 0)
                send_event(lva_pkg::FUNC_ALL_OFF, 0, 0, 8'hFF);
            else
                send_random_event();
        end
        gap_max = GAP_MAX;
    endtask

    task automatic test_drain_pause();
        wait_for_drain();
        for (int i = 0; i < 20; i++)
        begin
            send_random_event();
            if (i % 5 == 4)
                wait_for_drain();
        end
    endtask

    initial
    begin
        reset_allocation();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        test_no_idle();
        test_backpressure();
        test_drain_pause();
        wait_for_drain();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/lva_pkg.sv
sv/lva_order_cell.sv
sv/lva_note_table.sv
sv/lru_voice_allocator.sv
verif/lru_voice_allocator_tb.sv
